// ----- sv/ace_pkg.sv -----
// ============================================================================
// ace_pkg - shared types and constants for the color equalizer
// Command codes, controller states, register indexes and fixed widths.
// ============================================================================
package ace_pkg;

   localparam int MAX_WIDTH_DEF   = 256;
   localparam int MAX_HEIGHT_DEF  = 256;
   localparam int MAX_SAMPLES_DEF = 256;

   // configuration defaults
   localparam logic [8:0]  WIDTH_RESET  = 9'd256;
   localparam logic [8:0]  HEIGHT_RESET = 9'd256;
   localparam logic [8:0]  COUNT_RESET  = 9'd64;
   localparam logic [15:0] SLOPE_RESET  = 16'd2560;
   localparam logic [15:0] LIMIT_RESET  = 16'd1000;

   localparam logic signed [15:0] SCORE_MAX = 16'sd32767;

   // divide by five: (h * RAD_RECIP) >> RAD_SHIFT
   localparam int RAD_RECIP = 13108;
   localparam int RAD_SHIFT = 16;

   // shared divider
   localparam int DIV_NW = 74;
   localparam int DIV_DW = 58;
   localparam int DIV_SW = 7;

   localparam int WQ_W   = 49;   // 2^48 / d2
   localparam int WT_W   = 25;   // weight, at most 2^24
   localparam int NUM_W  = 59;
   localparam int DEN_W  = 58;
   localparam int RDQ_W  = 25;   // read quotient bits

   localparam int CSR_AW = 5;

   typedef enum logic [2:0] {
      REG_WIDTH  = 3'd0,
      REG_HEIGHT = 3'd1,
      REG_COUNT  = 3'd2,
      REG_SLOPE  = 3'd3,
      REG_LIMIT  = 3'd4
   } reg_index_type;

   typedef enum logic [1:0] {
      CMD_LOAD_PIXEL  = 2'd0,
      CMD_LOAD_SAMPLE = 2'd1,
      CMD_COMPUTE     = 2'd2,
      CMD_READ        = 2'd3
   } cmd_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_RD_CHAN,
      ST_RD_DIV,
      ST_C_RAD,
      ST_C_RAD2,
      ST_P_RD,
      ST_P_LATCH,
      ST_S_RD,
      ST_S_POS,
      ST_S_D2,
      ST_S_CHK,
      ST_S_WDIV,
      ST_S_SQRT,
      ST_S_DIFF,
      ST_S_MUL,
      ST_S_ACC,
      ST_P_SC,
      ST_P_SDIV,
      ST_P_WR
   } state_type;

endpackage

// ----- sv/automatic_color_equalizer_top.sv -----
// ============================================================================
// automatic_color_equalizer_top - automatic color equalization engine
// Holds an RGB image, a sample list and per-pixel scores in on-chip memory;
// computes per-channel scores on command and returns equalized pixels.
// ============================================================================
//  channel   | ports                         | handshake
//  request   | start, busy, req_*            | accepted when start && !busy
//  response  | rsp_strobe, rsp_*             | one cycle, cannot be held off
//  config    | psel, penable, pwrite, paddr  | APB, pready always high
//
//  Load pixel and load sample: written to memory on accept, back to back.
//  Read: up to three passes of the 25-step divider, one per channel.
//  Compute: radius setup, then per pixel three score divisions (none when the
//  weight sum is zero), plus per sample a distance check, and when used a weight division and root.
//  Reset is synchronous; the memories are not cleared and need no sweep.
//  The response side cannot stall; busy is high for a whole compute or read.
// ============================================================================
module automatic_color_equalizer_top #(
   parameter int MAX_WIDTH   = ace_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT  = ace_pkg::MAX_HEIGHT_DEF,
   parameter int MAX_SAMPLES = ace_pkg::MAX_SAMPLES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [1:0]                  req_cmd,
   input  logic [7:0]                  req_pos_x,
   input  logic [7:0]                  req_pos_y,
   input  logic [7:0]                  req_sample_index,
   input  logic [7:0]                  req_red,
   input  logic [7:0]                  req_green,
   input  logic [7:0]                  req_blue,
   output logic                        rsp_strobe,
   output logic [7:0]                  rsp_out_red,
   output logic [7:0]                  rsp_out_green,
   output logic [7:0]                  rsp_out_blue,
   output logic                        rsp_degenerate,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [ace_pkg::CSR_AW-1:0]  paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready
);

   localparam int XW   = $clog2(MAX_WIDTH);
   localparam int YW   = $clog2(MAX_HEIGHT);
   localparam int EWX  = $clog2(MAX_WIDTH + 1);
   localparam int EWY  = $clog2(MAX_HEIGHT + 1);
   localparam int AW   = $clog2(MAX_WIDTH * MAX_HEIGHT);
   localparam int SW   = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
   localparam int NCW  = $clog2(MAX_SAMPLES + 1);
   localparam int CWA  = (XW > YW) ? XW : YW;
   localparam int CW   = ((CWA > 8) ? CWA : 8) + 1;
   localparam int D2W  = 2 * CW;
   localparam int RW   = EWY - 2;
   localparam int RPW  = EWY + 14;
   localparam int NW   = ace_pkg::DIV_NW;
   localparam int DW   = ace_pkg::DIV_DW;
   localparam int DSW  = ace_pkg::DIV_SW;
   localparam int WQW  = ace_pkg::WQ_W;
   localparam int WTW  = ace_pkg::WT_W;
   localparam int NUMW = ace_pkg::NUM_W;
   localparam int DENW = ace_pkg::DEN_W;
   localparam int RQW  = ace_pkg::RDQ_W;

   // ---------------------------------------------------------------- config
   logic [8:0]  width_ff, height_ff, count_ff;
   logic [15:0] slope_ff, limit_ff;
   logic        csr_write;

   assign csr_write = psel && penable && pwrite && pready;
   assign pready    = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= ace_pkg::WIDTH_RESET;
         height_ff <= ace_pkg::HEIGHT_RESET;
         count_ff  <= ace_pkg::COUNT_RESET;
         slope_ff  <= ace_pkg::SLOPE_RESET;
         limit_ff  <= ace_pkg::LIMIT_RESET;
      end else if (csr_write) begin
         unique case (paddr[4:2])
            ace_pkg::REG_WIDTH:  width_ff  <= pwdata[8:0];
            ace_pkg::REG_HEIGHT: height_ff <= pwdata[8:0];
            ace_pkg::REG_COUNT:  count_ff  <= pwdata[8:0];
            ace_pkg::REG_SLOPE:  slope_ff  <= pwdata[15:0];
            ace_pkg::REG_LIMIT:  limit_ff  <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[4:2])
         ace_pkg::REG_WIDTH:  prdata = {23'd0, width_ff};
         ace_pkg::REG_HEIGHT: prdata = {23'd0, height_ff};
         ace_pkg::REG_COUNT:  prdata = {23'd0, count_ff};
         ace_pkg::REG_SLOPE:  prdata = {16'd0, slope_ff};
         ace_pkg::REG_LIMIT:  prdata = {16'd0, limit_ff};
         default:             prdata = '0;
      endcase
   end

   logic [EWX-1:0] eff_w;
   logic [EWY-1:0] eff_h;
   logic [NCW-1:0] eff_n;
   logic [23:0]    lim8;

   always_comb begin
      if (width_ff == 9'd0)                     eff_w = EWX'(1);
      else if (32'(width_ff) > 32'(MAX_WIDTH))  eff_w = EWX'(MAX_WIDTH);
      else                                      eff_w = EWX'(width_ff);
      if (height_ff == 9'd0)                    eff_h = EWY'(1);
      else if (32'(height_ff) > 32'(MAX_HEIGHT)) eff_h = EWY'(MAX_HEIGHT);
      else                                      eff_h = EWY'(height_ff);
      if (32'(count_ff) > 32'(MAX_SAMPLES))     eff_n = NCW'(MAX_SAMPLES);
      else                                      eff_n = NCW'(count_ff);
   end

   assign lim8 = {limit_ff, 8'd0};

   // ---------------------------------------------------------------- control
   ace_pkg::state_type state_ff, state_in;
   logic                      accept;
   ace_pkg::cmd_type          cmd;
   logic                      req_inside;

   assign accept     = start && !busy;
   assign busy       = state_ff != ace_pkg::ST_IDLE;
   assign cmd        = ace_pkg::cmd_type'(req_cmd);
   assign req_inside = (32'(req_pos_x) < 32'(MAX_WIDTH)) && (32'(req_pos_y) < 32'(MAX_HEIGHT));

   logic [XW-1:0]  x_ff, x_in;
   logic [YW-1:0]  y_ff, y_in;
   logic [NCW-1:0] k_ff, k_in;
   logic [1:0]     ch_ff, ch_in;
   logic [RW-1:0]  rad_ff, rad_in;
   logic [2*RW-1:0] rad2_ff, rad2_in;
   logic [RPW-1:0] rad_prod;
   logic [23:0]    cur_px_ff, cur_px_in;
   logic [23:0]    spx_ff, spx_in;
   logic           sin_ff, sin_in;
   logic signed [CW-1:0]  dx_ff, dx_in, dy_ff, dy_in;
   logic signed [D2W-1:0] dxx_ff, dxx_in, dyy_ff, dyy_in;
   logic [D2W-1:0] d2;
   logic [WQW-1:0] sv_ff, sv_in, sres_ff, sres_in, sbit_ff, sbit_in;
   logic [WQW:0]   sq_t;
   logic [WTW-1:0] wt;
   logic signed [25:0] s_ff [3];
   logic signed [25:0] s_in [3];
   logic signed [51:0] prod_ff [3];
   logic signed [51:0] prod_in [3];
   logic [48:0]    dprod_ff, dprod_in;
   logic signed [NUMW-1:0] num_ff [3];
   logic signed [NUMW-1:0] num_in [3];
   logic [DENW-1:0] den_ff, den_in;
   logic signed [15:0] min_ff [3];
   logic signed [15:0] min_in [3];
   logic signed [15:0] max_ff [3];
   logic signed [15:0] max_in [3];
   logic signed [15:0] sc_ff [3];
   logic signed [15:0] sc_in [3];
   logic           rdin_ff, rdin_in;
   logic [7:0]     out_ff [3];
   logic [7:0]     out_in [3];
   logic           degen_ff, degen_in;
   logic           strobe_ff, strobe_in;

   logic           rd_next, s_next, sc_next, sc_take;
   logic signed [15:0] sc_new;
   logic signed [NUMW-1:0] num_abs;
   logic signed [8:0]  diff9;
   logic signed [25:0] pd;
   logic signed [25:0] lims;
   logic signed [15:0] rd_sc, rd_lo, rd_hi;
   logic signed [16:0] rd_span, rd_off;
   logic [23:0]    rd_scaled;
   logic [15:0]    q16;

   logic           div_start;
   logic [NW-1:0]  div_dividend;
   logic [DW-1:0]  div_divisor;
   logic [DSW-1:0] div_steps;
   logic           div_done;
   logic [NW-1:0]  div_q;

   // ---------------------------------------------------------------- memories
   logic [23:0] pix_mem [MAX_WIDTH*MAX_HEIGHT];
   logic [47:0] score_mem [MAX_WIDTH*MAX_HEIGHT];
   logic [15:0] sample_mem [2**SW];
   logic [23:0] pix_q_ff;
   logic [47:0] score_q_ff;
   logic [15:0] sample_q_ff;
   logic [AW-1:0] cur_addr, req_addr, samp_addr, pix_raddr;
   logic [7:0]    sx, sy;

   assign sx        = sample_q_ff[7:0];
   assign sy        = sample_q_ff[15:8];
   assign cur_addr  = AW'(y_ff) * AW'(MAX_WIDTH) + AW'(x_ff);
   assign req_addr  = AW'(req_pos_y) * AW'(MAX_WIDTH) + AW'(req_pos_x);
   assign samp_addr = AW'(sy) * AW'(MAX_WIDTH) + AW'(sx);
   assign pix_raddr = (state_ff == ace_pkg::ST_S_POS) ? samp_addr : cur_addr;

   always_ff @(posedge clock) begin
      if (accept && cmd == ace_pkg::CMD_LOAD_PIXEL && req_inside) begin
         pix_mem[req_addr] <= {req_red, req_green, req_blue};
      end
      pix_q_ff <= pix_mem[pix_raddr];
   end

   always_ff @(posedge clock) begin
      if (state_ff == ace_pkg::ST_P_WR) begin
         score_mem[cur_addr] <= {sc_ff[0], sc_ff[1], sc_ff[2]};
      end
      if (accept && cmd == ace_pkg::CMD_READ) begin
         score_q_ff <= score_mem[req_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (accept && cmd == ace_pkg::CMD_LOAD_SAMPLE &&
          32'(req_sample_index) < 32'(MAX_SAMPLES)) begin
         sample_mem[SW'(req_sample_index)] <= {req_pos_y, req_pos_x};
      end
      sample_q_ff <= sample_mem[k_ff[SW-1:0]];
   end

   ace_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .steps    (div_steps),
      .done     (div_done),
      .quotient (div_q)
   );

   assign rad_prod = RPW'(eff_h) * RPW'(ace_pkg::RAD_RECIP);
   assign d2       = dxx_ff + dyy_ff;
   assign wt       = sres_ff[WTW-1:0];
   assign lims     = $signed({2'b00, lim8});
   assign num_abs  = num_ff[ch_ff][NUMW-1] ? -num_ff[ch_ff] : num_ff[ch_ff];
   assign rd_sc    = score_q_ff[47-16*ch_ff -: 16];
   assign rd_lo    = min_ff[ch_ff];
   assign rd_hi    = max_ff[ch_ff];
   assign rd_span  = 17'(rd_hi) - 17'(rd_lo);
   assign rd_off   = 17'(rd_sc) - 17'(rd_lo);
   assign rd_scaled = 24'({rd_off[15:0], 8'd0}) - 24'(rd_off[15:0]);
   assign q16      = (div_q[15:0] > 16'(ace_pkg::SCORE_MAX)) ?
                     16'(ace_pkg::SCORE_MAX) : div_q[15:0];

   always_comb begin
      state_in  = state_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      k_in      = k_ff;
      ch_in     = ch_ff;
      rad_in    = rad_ff;
      rad2_in   = rad2_ff;
      cur_px_in = cur_px_ff;
      spx_in    = spx_ff;
      sin_in    = sin_ff;
      dx_in     = dx_ff;
      dy_in     = dy_ff;
      dxx_in    = dxx_ff;
      dyy_in    = dyy_ff;
      sv_in     = sv_ff;
      sres_in   = sres_ff;
      sbit_in   = sbit_ff;
      dprod_in  = dprod_ff;
      den_in    = den_ff;
      rdin_in   = rdin_ff;
      degen_in  = degen_ff;
      strobe_in = 1'b0;
      sq_t      = '0;
      diff9     = '0;
      pd        = '0;
      for (int c = 0; c < 3; c++) begin
         s_in[c]    = s_ff[c];
         prod_in[c] = prod_ff[c];
         num_in[c]  = num_ff[c];
         min_in[c]  = min_ff[c];
         max_in[c]  = max_ff[c];
         sc_in[c]   = sc_ff[c];
         out_in[c]  = out_ff[c];
      end
      rd_next      = 1'b0;
      s_next       = 1'b0;
      sc_next      = 1'b0;
      sc_take      = 1'b0;
      sc_new       = '0;
      div_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = '0;
      div_steps    = '0;

      unique case (state_ff)
         ace_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (cmd)
                  ace_pkg::CMD_COMPUTE: begin
                     state_in = ace_pkg::ST_C_RAD;
                     for (int c = 0; c < 3; c++) begin
                        max_in[c] = '0;
                        min_in[c] = ace_pkg::SCORE_MAX;
                     end
                  end
                  ace_pkg::CMD_READ: begin
                     state_in = ace_pkg::ST_RD_CHAN;
                     ch_in    = 2'd0;
                     degen_in = 1'b0;
                     rdin_in  = req_inside;
                  end
                  default: ;
               endcase
            end
         end
         ace_pkg::ST_RD_CHAN: begin
            if (rd_hi <= rd_lo) begin
               degen_in      = 1'b1;
               out_in[ch_ff] = '0;
               rd_next       = 1'b1;
            end else if (!rdin_ff || rd_sc <= rd_lo) begin
               out_in[ch_ff] = '0;
               rd_next       = 1'b1;
            end else begin
               div_start    = 1'b1;
               div_dividend = {RQW'(rd_scaled), (NW-RQW)'(0)};
               div_divisor  = DW'(rd_span[15:0] == 16'd0 ? 17'h10000 : 17'(rd_span[15:0]));
               div_steps    = DSW'(RQW);
               state_in     = ace_pkg::ST_RD_DIV;
            end
         end
         ace_pkg::ST_RD_DIV: begin
            if (div_done) begin
               out_in[ch_ff] = (div_q[RQW-1:0] > RQW'(255)) ? 8'd255 : div_q[7:0];
               rd_next       = 1'b1;
            end
         end
         ace_pkg::ST_C_RAD: begin
            rad_in   = rad_prod[RPW-1:ace_pkg::RAD_SHIFT];
            state_in = ace_pkg::ST_C_RAD2;
         end
         ace_pkg::ST_C_RAD2: begin
            rad2_in  = (2*RW)'(rad_ff) * (2*RW)'(rad_ff);
            x_in     = '0;
            y_in     = '0;
            state_in = ace_pkg::ST_P_RD;
         end
         ace_pkg::ST_P_RD: begin
            k_in   = '0;
            den_in = '0;
            for (int c = 0; c < 3; c++) num_in[c] = '0;
            state_in = ace_pkg::ST_P_LATCH;
         end
         ace_pkg::ST_P_LATCH: begin
            cur_px_in = pix_q_ff;
            ch_in     = 2'd0;
            state_in  = (eff_n == '0) ? ace_pkg::ST_P_SC : ace_pkg::ST_S_RD;
         end
         ace_pkg::ST_S_RD: begin
            state_in = ace_pkg::ST_S_POS;
         end
         ace_pkg::ST_S_POS: begin
            dx_in    = $signed(CW'(x_ff)) - $signed(CW'(sx));
            dy_in    = $signed(CW'(y_ff)) - $signed(CW'(sy));
            sin_in   = (32'(sx) < 32'(MAX_WIDTH)) && (32'(sy) < 32'(MAX_HEIGHT));
            state_in = ace_pkg::ST_S_D2;
         end
         ace_pkg::ST_S_D2: begin
            dxx_in   = dx_ff * dx_ff;
            dyy_in   = dy_ff * dy_ff;
            spx_in   = sin_ff ? pix_q_ff : 24'd0;
            state_in = ace_pkg::ST_S_CHK;
         end
         ace_pkg::ST_S_CHK: begin
            if (d2 == '0 || d2 < D2W'(rad2_ff)) begin
               s_next = 1'b1;
            end else begin
               div_start    = 1'b1;
               div_dividend = {1'b1, (NW-1)'(0)};
               div_divisor  = DW'(d2);
               div_steps    = DSW'(WQW);
               state_in     = ace_pkg::ST_S_WDIV;
            end
         end
         ace_pkg::ST_S_WDIV: begin
            if (div_done) begin
               sv_in    = div_q[WQW-1:0];
               sres_in  = '0;
               sbit_in  = {1'b1, (WQW-1)'(0)};
               state_in = ace_pkg::ST_S_SQRT;
            end
         end
         ace_pkg::ST_S_SQRT: begin
            sq_t = {1'b0, sres_ff} + {1'b0, sbit_ff};
            if ({1'b0, sv_ff} >= sq_t) begin
               sv_in   = sv_ff - sq_t[WQW-1:0];
               sres_in = (sres_ff >> 1) + sbit_ff;
            end else begin
               sres_in = sres_ff >> 1;
            end
            sbit_in = sbit_ff >> 2;
            if (sbit_ff[0]) state_in = ace_pkg::ST_S_DIFF;
         end
         ace_pkg::ST_S_DIFF: begin
            for (int c = 0; c < 3; c++) begin
               diff9 = $signed({1'b0, cur_px_ff[23-8*c -: 8]}) -
                       $signed({1'b0, spx_ff[23-8*c -: 8]});
               pd    = 26'(diff9) * $signed({10'd0, slope_ff});
               if (pd > lims)       s_in[c] = lims;
               else if (pd < -lims) s_in[c] = -lims;
               else                 s_in[c] = pd;
            end
            state_in = ace_pkg::ST_S_MUL;
         end
         ace_pkg::ST_S_MUL: begin
            for (int c = 0; c < 3; c++) begin
               prod_in[c] = 52'(s_ff[c]) * $signed({27'd0, wt});
            end
            dprod_in = 49'(lim8) * 49'(wt);
            state_in = ace_pkg::ST_S_ACC;
         end
         ace_pkg::ST_S_ACC: begin
            for (int c = 0; c < 3; c++) begin
               num_in[c] = num_ff[c] + NUMW'(prod_ff[c]);
            end
            den_in = den_ff + DENW'(dprod_ff);
            s_next = 1'b1;
         end
         ace_pkg::ST_P_SC: begin
            if (den_ff == '0) begin
               sc_new  = '0;
               sc_take = 1'b1;
            end else begin
               div_start    = 1'b1;
               div_dividend = NW'({num_abs[DENW-1:0], 15'd0});
               div_divisor  = DW'(den_ff);
               div_steps    = DSW'(NW);
               state_in     = ace_pkg::ST_P_SDIV;
            end
         end
         ace_pkg::ST_P_SDIV: begin
            if (div_done) begin
               sc_new  = num_ff[ch_ff][NUMW-1] ? -$signed(q16) : $signed(q16);
               sc_take = 1'b1;
            end
         end
         ace_pkg::ST_P_WR: begin
            state_in = ace_pkg::ST_P_RD;
            if (EWX'(x_ff) + EWX'(1) == eff_w) begin
               x_in = '0;
               if (EWY'(y_ff) + EWY'(1) == eff_h) state_in = ace_pkg::ST_IDLE;
               else y_in = y_ff + YW'(1);
            end else begin
               x_in = x_ff + XW'(1);
            end
         end
         default: state_in = ace_pkg::ST_IDLE;
      endcase

      // advance to the next read channel
      if (rd_next) begin
         if (ch_ff == 2'd2) begin
            strobe_in = 1'b1;
            state_in  = ace_pkg::ST_IDLE;
         end else begin
            ch_in    = ch_ff + 2'd1;
            state_in = ace_pkg::ST_RD_CHAN;
         end
      end

      // advance to the next sample
      if (s_next) begin
         if (k_ff + NCW'(1) == eff_n) begin
            ch_in    = 2'd0;
            state_in = ace_pkg::ST_P_SC;
         end else begin
            k_in     = k_ff + NCW'(1);
            state_in = ace_pkg::ST_S_RD;
         end
      end

      // record a finished score and track the channel range
      if (sc_take) begin
         sc_in[ch_ff] = sc_new;
         if (sc_new > max_ff[ch_ff]) max_in[ch_ff] = sc_new;
         if (sc_new < min_ff[ch_ff]) min_in[ch_ff] = sc_new;
         sc_next = 1'b1;
      end
      if (sc_next) begin
         if (ch_ff == 2'd2) begin
            state_in = ace_pkg::ST_P_WR;
         end else begin
            ch_in    = ch_ff + 2'd1;
            state_in = ace_pkg::ST_P_SC;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ace_pkg::ST_IDLE;
         strobe_ff <= 1'b0;
         for (int c = 0; c < 3; c++) begin
            min_ff[c] <= ace_pkg::SCORE_MAX;
            max_ff[c] <= '0;
         end
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
         for (int c = 0; c < 3; c++) begin
            min_ff[c] <= min_in[c];
            max_ff[c] <= max_in[c];
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff      <= x_in;
      y_ff      <= y_in;
      k_ff      <= k_in;
      ch_ff     <= ch_in;
      rad_ff    <= rad_in;
      rad2_ff   <= rad2_in;
      cur_px_ff <= cur_px_in;
      spx_ff    <= spx_in;
      sin_ff    <= sin_in;
      dx_ff     <= dx_in;
      dy_ff     <= dy_in;
      dxx_ff    <= dxx_in;
      dyy_ff    <= dyy_in;
      sv_ff     <= sv_in;
      sres_ff   <= sres_in;
      sbit_ff   <= sbit_in;
      dprod_ff  <= dprod_in;
      den_ff    <= den_in;
      rdin_ff   <= rdin_in;
      degen_ff  <= degen_in;
      for (int c = 0; c < 3; c++) begin
         s_ff[c]    <= s_in[c];
         prod_ff[c] <= prod_in[c];
         num_ff[c]  <= num_in[c];
         sc_ff[c]   <= sc_in[c];
         out_ff[c]  <= out_in[c];
      end
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_out_red    = out_ff[0];
   assign rsp_out_green  = out_ff[1];
   assign rsp_out_blue   = out_ff[2];
   assign rsp_degenerate = degen_ff;

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      strobe_ff |=> !strobe_ff) else $error("two responses in a row");

   a_read_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && req_cmd == ace_pkg::CMD_READ) |=> busy)
      else $error("read transaction did not hold busy");

   a_sqrt_bit: assert property (@(posedge clock) disable iff (reset)
      state_ff == ace_pkg::ST_S_SQRT |-> sbit_ff != '0)
      else $error("root iteration ran past its last bit");

   a_div_owner: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ace_pkg::ST_RD_DIV || state_ff == ace_pkg::ST_S_WDIV ||
                    state_ff == ace_pkg::ST_P_SDIV))
      else $error("divider result with no waiting state");

endmodule

// ----- sv/ace_div.sv -----
// ============================================================================
// ace_div - shared restoring divider
// Unsigned, one quotient bit per cycle. The dividend arrives left-aligned and
// steps gives the number of significant bits; done pulses with the quotient.
// ============================================================================
module ace_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [ace_pkg::DIV_NW-1:0]  dividend,
   input  logic [ace_pkg::DIV_DW-1:0]  divisor,
   input  logic [ace_pkg::DIV_SW-1:0]  steps,
   output logic                        done,
   output logic [ace_pkg::DIV_NW-1:0]  quotient
);

   localparam int NW = ace_pkg::DIV_NW;
   localparam int DW = ace_pkg::DIV_DW;
   localparam int SW = ace_pkg::DIV_SW;

   logic          run_ff,  run_in;
   logic          done_ff, done_in;
   logic [SW-1:0] cnt_ff,  cnt_in;
   logic [NW-1:0] q_ff,    q_in;
   logic [DW-1:0] r_ff,    r_in;
   logic [DW-1:0] d_ff,    d_in;
   logic [DW:0]   rr;
   logic [DW:0]   diff;
   logic          ge;

   always_comb begin
      rr     = {r_ff, q_ff[NW-1]};
      diff   = rr - {1'b0, d_ff};
      ge     = rr >= {1'b0, d_ff};
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      q_in    = q_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = steps;
         q_in   = dividend;
         r_in   = '0;
         d_in   = divisor;
      end else if (run_ff) begin
         q_in   = {q_ff[NW-2:0], ge};
         r_in   = ge ? diff[DW-1:0] : rr[DW-1:0];
         cnt_in = cnt_ff - SW'(1);
         if (cnt_ff == SW'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      q_ff   <= q_in;
      r_ff   <= r_in;
      d_ff   <= d_in;
   end

   assign done     = done_ff;
   assign quotient = q_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !run_ff) else $error("divider restarted while running");

   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !run_ff) else $error("divider done while running");

   a_done_end: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(run_ff)) else $error("divider done without a run");

endmodule

// ----- test/automatic_color_equalizer_top_tb.sv -----
`timescale 1ns / 100ps
// ============================================================================
// automatic_color_equalizer_top_tb - regression for the color equalizer
// Loads small images and sample lists, runs compute and reads back the
// equalized pixels. An in-bench model of the scoring arithmetic predicts each
// read. Phases vary the register settings and the request idle rate.
// ============================================================================
module automatic_color_equalizer_top_tb;

   typedef struct {
      bit [7:0] red;
      bit [7:0] green;
      bit [7:0] blue;
      bit       degen;
   } eq_pixel_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_cmd = '0;
   logic [7:0]  req_pos_x = '0, req_pos_y = '0, req_sample_index = '0;
   logic [7:0]  req_red = '0, req_green = '0, req_blue = '0;
   logic        rsp_strobe;
   logic [7:0]  rsp_out_red, rsp_out_green, rsp_out_blue;
   logic        rsp_degenerate;
   logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [ace_pkg::CSR_AW-1:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   // model state
   bit [23:0]   pixel_mem [65536];
   shortint     score_mem [65536][3];
   bit [15:0]   sample_mem [256];
   int          chan_max [3];
   int          chan_min [3];
   bit [8:0]    cfg_width, cfg_height, cfg_count;
   bit [15:0]   cfg_slope, cfg_limit;

   eq_pixel_type pending_pixels [$];
   bit [15:0]   loaded_pos [$];
   bit [15:0]   scored_pos [$];
   bit          scored_flag [65536];
   int          errors = 0;
   int          items = 0;
   int          idle_pct = 0;

   automatic_color_equalizer_top DUT (.*);

   always #6 clock = ~clock;

   initial begin
      #200000000;
      $display("automatic_color_equalizer_top regression: fail");
      $finish;
   end

   task automatic report(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      errors++;
   endtask

   always @(posedge clock) begin
      eq_pixel_type e;
      if (!reset && rsp_strobe) begin
         if (pending_pixels.size() == 0) begin
            report("result with no read outstanding");
         end else begin
            e = pending_pixels.pop_front();
            if (rsp_out_red !== e.red)
               report($sformatf("red %0d exp %0d", rsp_out_red, e.red));
            if (rsp_out_green !== e.green)
               report($sformatf("green %0d exp %0d", rsp_out_green, e.green));
            if (rsp_out_blue !== e.blue)
               report($sformatf("blue %0d exp %0d", rsp_out_blue, e.blue));
            if (rsp_degenerate !== e.degen)
               report($sformatf("degenerate %0d exp %0d", rsp_degenerate, e.degen));
         end
      end
   end

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res = 0;
      longint unsigned b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   function automatic int score_of(longint num, longint unsigned den);
      longint unsigned r, q;
      if (den == 0) return 0;
      r = num < 0 ? longint'(-num) : longint'(num);
      q = 0;
      if (r >= den) begin
         q = 1;
         r -= den;
      end
      for (int i = 0; i < 15; i++) begin
         r <<= 1;
         q <<= 1;
         if (r >= den) begin
            q |= 1;
            r -= den;
         end
      end
      if (q > 32767) q = 32767;
      return num < 0 ? -int'(q) : int'(q);
   endfunction

   function automatic int chan_of(bit [23:0] px, int c);
      return (px >> (16 - 8 * c)) & 8'hFF;
   endfunction

   function automatic void compute_scores();
      int w, h, n, sc;
      longint rad, lim8, dx, dy, s;
      longint unsigned d2, wt, den;
      longint num [3];
      bit [23:0] px, spx;
      bit [7:0] sx, sy;
      w = cfg_width < 1 ? 1 : (cfg_width > 256 ? 256 : cfg_width);
      h = cfg_height < 1 ? 1 : (cfg_height > 256 ? 256 : cfg_height);
      n = cfg_count > 256 ? 256 : cfg_count;
      rad = h / 5;
      lim8 = longint'(cfg_limit) * 256;
      for (int c = 0; c < 3; c++) begin
         chan_max[c] = 0;
         chan_min[c] = 32767;
      end
      for (int y = 0; y < h; y++) begin
         for (int x = 0; x < w; x++) begin
            px = pixel_mem[y * 256 + x];
            num = '{0, 0, 0};
            den = 0;
            for (int k = 0; k < n; k++) begin
               sx = sample_mem[k][7:0];
               sy = sample_mem[k][15:8];
               dx = longint'(x) - longint'(sx);
               dy = longint'(y) - longint'(sy);
               d2 = dx * dx + dy * dy;
               if (d2 == 0 || d2 < rad * rad) continue;
               spx = pixel_mem[sy * 256 + sx];
               wt = int_sqrt((64'd1 << 48) / d2);
               for (int c = 0; c < 3; c++) begin
                  s = longint'(chan_of(px, c) - chan_of(spx, c)) * cfg_slope;
                  if (s > lim8) s = lim8;
                  if (s < -lim8) s = -lim8;
                  num[c] += s * longint'(wt);
               end
               den += lim8 * wt;
            end
            for (int c = 0; c < 3; c++) begin
               sc = score_of(num[c], den);
               score_mem[y * 256 + x][c] = shortint'(sc);
               if (sc > chan_max[c]) chan_max[c] = sc;
               if (sc < chan_min[c]) chan_min[c] = sc;
            end
            if (!scored_flag[y * 256 + x]) begin
               scored_flag[y * 256 + x] = 1'b1;
               scored_pos.push_back({8'(y), 8'(x)});
            end
         end
      end
   endfunction

   function automatic void equalize_predict(ace_pkg::cmd_type cmd, bit [7:0] x, bit [7:0] y,
                                            bit [7:0] idx, bit [23:0] rgb);
      eq_pixel_type e;
      longint lo, hi, sc, q;
      bit [7:0] v [3];
      case (cmd)
         ace_pkg::CMD_LOAD_PIXEL: begin
            pixel_mem[{y, x}] = rgb;
            loaded_pos.push_back({y, x});
         end
         ace_pkg::CMD_LOAD_SAMPLE: sample_mem[idx] = {y, x};
         ace_pkg::CMD_COMPUTE: compute_scores();
         ace_pkg::CMD_READ: begin
            e.degen = 1'b0;
            for (int c = 0; c < 3; c++) begin
               lo = chan_min[c];
               hi = chan_max[c];
               v[c] = 0;
               if (hi <= lo) begin
                  e.degen = 1'b1;
               end else begin
                  sc = score_mem[{y, x}][c];
                  if (sc > lo) begin
                     q = (sc - lo) * 255 / (hi - lo);
                     v[c] = q > 255 ? 8'd255 : 8'(q);
                  end
               end
            end
            e.red = v[0];
            e.green = v[1];
            e.blue = v[2];
            pending_pixels.push_back(e);
         end
      endcase
   endfunction

   task automatic send(ace_pkg::cmd_type cmd, bit [7:0] x, bit [7:0] y, bit [7:0] idx,
                       bit [23:0] rgb);
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      start <= 1'b1;
      req_cmd <= cmd;
      req_pos_x <= x;
      req_pos_y <= y;
      req_sample_index <= idx;
      {req_red, req_green, req_blue} <= rgb;
      @(posedge clock);
      while (busy) @(posedge clock);
      equalize_predict(cmd, x, y, idx, rgb);
      items++;
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending_pixels.size() != 0 || busy) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic csr_write(ace_pkg::reg_index_type r, bit [31:0] value);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= ace_pkg::CSR_AW'(4 * r);
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      case (r)
         ace_pkg::REG_WIDTH:  cfg_width = value[8:0];
         ace_pkg::REG_HEIGHT: cfg_height = value[8:0];
         ace_pkg::REG_COUNT:  cfg_count = value[8:0];
         ace_pkg::REG_SLOPE:  cfg_slope = value[15:0];
         ace_pkg::REG_LIMIT:  cfg_limit = value[15:0];
      endcase
   endtask

   function automatic bit [23:0] pick_color();
      bit [23:0] rgb;
      for (int c = 0; c < 3; c++) begin
         case ($urandom_range(3))
            0: rgb[c*8 +: 8] = 8'h00;
            1: rgb[c*8 +: 8] = 8'hFF;
            default: rgb[c*8 +: 8] = 8'($urandom);
         endcase
      end
      return rgb;
   endfunction

   function automatic bit all_degenerate();
      for (int c = 0; c < 3; c++)
         if (chan_max[c] > chan_min[c]) return 1'b0;
      return 1'b1;
   endfunction

   task automatic read_some(int count);
      bit [15:0] p;
      for (int i = 0; i < count; i++) begin
         if (all_degenerate() || scored_pos.size() == 0) p = 16'($urandom);
         else p = scored_pos[$urandom_range(scored_pos.size() - 1)];
         send(ace_pkg::CMD_READ, p[7:0], p[15:8], 8'($urandom), 24'($urandom));
         if ($urandom_range(9) == 0)
            send(ace_pkg::CMD_LOAD_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom),
                 pick_color());
      end
   endtask

   // load a w x h image and n samples, compute, read back
   task automatic run_frame(bit [8:0] w, bit [8:0] h, bit [8:0] n,
                            bit [15:0] slope, bit [15:0] lim, int reads);
      int ew, eh, en;
      bit [15:0] p;
      drain();
      csr_write(ace_pkg::REG_WIDTH, w);
      csr_write(ace_pkg::REG_HEIGHT, h);
      csr_write(ace_pkg::REG_COUNT, n);
      csr_write(ace_pkg::REG_SLOPE, slope);
      csr_write(ace_pkg::REG_LIMIT, lim);
      ew = w < 1 ? 1 : (w > 256 ? 256 : w);
      eh = h < 1 ? 1 : (h > 256 ? 256 : h);
      en = n > 256 ? 256 : n;
      repeat ($urandom_range(3))
         send(ace_pkg::CMD_LOAD_SAMPLE, 8'($urandom), 8'($urandom), 8'($urandom),
              24'($urandom));
      for (int y = 0; y < eh; y++)
         for (int x = 0; x < ew; x++)
            send(ace_pkg::CMD_LOAD_PIXEL, 8'(x), 8'(y), 8'($urandom), pick_color());
      for (int k = 0; k < en; k++) begin
         if ($urandom_range(3) == 0)
            p = loaded_pos[$urandom_range(loaded_pos.size() - 1)];
         else
            p = {8'($urandom_range(eh - 1)), 8'($urandom_range(ew - 1))};
         send(ace_pkg::CMD_LOAD_SAMPLE, p[7:0], p[15:8], 8'(k), 24'($urandom));
      end
      send(ace_pkg::CMD_COMPUTE, 8'($urandom), 8'($urandom), 8'($urandom), 24'($urandom));
      read_some(reads);
   endtask

   task automatic test_reset_state();
      send(ace_pkg::CMD_READ, 8'h00, 8'h00, 8'h00, 24'h000000);
      send(ace_pkg::CMD_READ, 8'hFF, 8'hFF, 8'hFF, 24'hFFFFFF);
      send(ace_pkg::CMD_LOAD_PIXEL, 8'hFF, 8'hFF, 8'hAA, 24'hFFFFFF);
      send(ace_pkg::CMD_LOAD_PIXEL, 8'h00, 8'h00, 8'h55, 24'h000000);
      send(ace_pkg::CMD_LOAD_SAMPLE, 8'hFF, 8'hFF, 8'hFF, 24'h0);
   endtask

   task automatic test_directed_image();
      // self-distance sample, strong contrast, zero slope, tiny limit
      run_frame(9'd3, 9'd2, 9'd4, 16'd2560, 16'd1000, 6);
      run_frame(9'd2, 9'd2, 9'd3, 16'd0, 16'd1000, 3);
      run_frame(9'd3, 9'd1, 9'd2, 16'd65535, 16'd1, 3);
      run_frame(9'd2, 9'd2, 9'd3, 16'd65535, 16'd65535, 3);
   endtask

   task automatic test_exclusion_radius();
      run_frame(9'd1, 9'd10, 9'd6, 16'd2560, 16'd1000, 6);
      run_frame(9'd2, 9'd5, 9'd5, 16'($urandom), 16'($urandom_range(1, 65535)), 5);
   endtask

   task automatic test_count_extremes();
      run_frame(9'd0, 9'd2, 9'd0, 16'd2560, 16'd1000, 3);
      run_frame(9'd1, 9'd2, 9'd511, 16'd300, 16'd500, 4);
      run_frame(9'd2, 9'd1, 9'd256, 16'd2560, 16'd65535, 4);
   endtask

   task automatic test_stale_scores();
      // shrink the image so reads of older scores fall outside min..max
      run_frame(9'd5, 9'd5, 9'd6, 16'd4000, 16'd800, 4);
      run_frame(9'd1, 9'd1, 9'd2, 16'd100, 16'd900, 15);
   endtask

   task automatic test_wide_registers();
      drain();
      csr_write(ace_pkg::REG_WIDTH, 9'd511);
      csr_write(ace_pkg::REG_HEIGHT, 9'd256);
      read_some(8);
   endtask

   task automatic test_random();
      int phase = 0;
      int rates [4] = '{0, 82, 31, 0};
      while (items < 950) begin
         idle_pct = rates[phase % 4];
         phase++;
         run_frame(9'($urandom_range(1, 5)), 9'($urandom_range(1, 6)),
                   9'($urandom_range(0, 8)),
                   $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(64, 6000)),
                   $urandom_range(3) == 0 ? 16'($urandom_range(1, 65535))
                                          : 16'($urandom_range(50, 2000)),
                   $urandom_range(15, 35));
      end
   endtask

   initial begin
      cfg_width = ace_pkg::WIDTH_RESET;
      cfg_height = ace_pkg::HEIGHT_RESET;
      cfg_count = ace_pkg::COUNT_RESET;
      cfg_slope = ace_pkg::SLOPE_RESET;
      cfg_limit = ace_pkg::LIMIT_RESET;
      for (int c = 0; c < 3; c++) begin
         chan_max[c] = 0;
         chan_min[c] = 32767;
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_state();
      test_directed_image();
      test_exclusion_radius();
      test_count_extremes();
      test_stale_scores();
      test_wide_registers();
      test_random();
      drain();
      if (errors == 0) begin
         $display("automatic_color_equalizer_top regression: pass");
      end else begin
         $display("automatic_color_equalizer_top regression: fail");
      end
      $finish;
   end

endmodule

// ----- automatic_color_equalizer_top.f -----
sv/ace_pkg.sv
sv/ace_div.sv
sv/automatic_color_equalizer_top.sv
test/automatic_color_equalizer_top_tb.sv
